// ----- design/log_record_deframer_crc32_macros.svh -----
// Assertion macros shared by the log record deframer modules.
// Expects signals named clock and reset in the scope of each use.
`ifndef LOG_RECORD_DEFRAMER_CRC32_MACROS_SVH
`define LOG_RECORD_DEFRAMER_CRC32_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define LRD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define LRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/lrd_pkg.sv -----
// Types, codes and the CRC-32 byte step for the log record deframer.
// No dependencies; used by the front, queue, back and top level.
package lrd_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
   localparam logic [3:0]  HDR_LAST_POS = 4'd15;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_STOP = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      VERDICT_PENDING   = 2'd0,
      VERDICT_GOOD      = 2'd1,
      VERDICT_MISMATCH  = 2'd2,
      VERDICT_TRUNCATED = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_LAST  = 2'd1,
      OP_EMPTY = 2'd2,
      OP_TRUNC = 2'd3
   } op_code_type;

   typedef struct packed {
      op_code_type code;
      logic [7:0]  data;
      logic [63:0] record_seq;
      logic [31:0] check_word;
      logic        skip;
   } lrd_op_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } lrd_q_status_type;

   function automatic logic [31:0] lrd_crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- design/lrd_req_if.sv -----
// Request channel of the log record deframer: stream kind and byte.
// No dependencies.
interface lrd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;

   modport source (output valid, kind, data_byte, input ready);
   modport sink (input valid, kind, data_byte, output ready);
endinterface

// ----- design/lrd_rsp_if.sv -----
// Result channel of the log record deframer: forwarded byte and verdict.
// No dependencies.
interface lrd_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_byte;
   logic [7:0]  data_byte_res;
   logic [63:0] record_sequence;
   logic        last_of_record;
   logic [1:0]  verdict;

   modport source (output valid, has_byte, data_byte_res, record_sequence,
                   last_of_record, verdict, input ready);
   modport sink (input valid, has_byte, data_byte_res, record_sequence,
                 last_of_record, verdict, output ready);
endinterface

// ----- design/lrd_front.sv -----
// Front part: accepts requests, assembles headers, counts payload, queues ops.
// Depends on lrd_pkg and lrd_req_if; holds the start_sequence register.
module lrd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [63:0]               csr_wdata,
   lrd_req_if.sink                   req_ch,
   input  lrd_pkg::lrd_q_status_type q_status,
   output logic                      push,
   output lrd_pkg::lrd_op_type       push_op
);
   import lrd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_HALTED
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_pos_ff, hdr_pos_in;
   logic [63:0] seq_ff, seq_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] left_ff, left_in;
   logic        skip_ff, skip_in;
   logic [63:0] start_seq_ff, start_seq_in;
   logic        accept;

   assign req_ch.ready = !q_status.full;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      phase_in     = phase_ff;
      hdr_pos_in   = hdr_pos_ff;
      seq_in       = seq_ff;
      len_in       = len_ff;
      crc_in       = crc_ff;
      left_in      = left_ff;
      skip_in      = skip_ff;
      start_seq_in = csr_we ? csr_wdata : start_seq_ff;
      push         = 1'b0;
      push_op      = '{code: OP_BYTE, data: req_ch.data_byte, record_seq: seq_ff,
                       check_word: crc_ff, skip: skip_ff};
      if (accept && phase_ff != PH_HALTED) begin
         case (kind_type'(req_ch.kind))
            KIND_STOP: begin
               phase_in = PH_HALTED;
            end
            KIND_END: begin
               if (!(phase_ff == PH_HEADER && hdr_pos_ff == 4'd0)) begin
                  phase_in     = PH_HALTED;
                  push         = 1'b1;
                  push_op.code = OP_TRUNC;
               end
            end
            KIND_BYTE: begin
               if (phase_ff == PH_HEADER) begin
                  if (hdr_pos_ff == 4'd0) begin
                     seq_in = '0;
                     len_in = '0;
                     crc_in = '0;
                  end
                  priority if (!hdr_pos_ff[3]) begin
                     seq_in[{hdr_pos_ff[2:0], 3'b000} +: 8] = req_ch.data_byte;
                  end else if (!hdr_pos_ff[2]) begin
                     len_in[{hdr_pos_ff[1:0], 3'b000} +: 8] = req_ch.data_byte;
                  end else begin
                     crc_in[{hdr_pos_ff[1:0], 3'b000} +: 8] = req_ch.data_byte;
                  end
                  if (hdr_pos_ff == HDR_LAST_POS) begin
                     hdr_pos_in = 4'd0;
                     left_in    = len_ff;
                     skip_in    = seq_ff < start_seq_ff;
                     if (len_ff == 32'd0) begin
                        push               = 1'b1;
                        push_op.code       = OP_EMPTY;
                        push_op.check_word = crc_in;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end else begin
                     hdr_pos_in = hdr_pos_ff + 4'd1;
                  end
               end else begin
                  left_in = left_ff - 32'd1;
                  push    = 1'b1;
                  if (left_ff == 32'd1) begin
                     push_op.code = OP_LAST;
                     phase_in     = PH_HEADER;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_pos_ff   <= 4'd0;
         seq_ff       <= '0;
         len_ff       <= '0;
         crc_ff       <= '0;
         left_ff      <= '0;
         skip_ff      <= 1'b0;
         start_seq_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_pos_ff   <= hdr_pos_in;
         seq_ff       <= seq_in;
         len_ff       <= len_in;
         crc_ff       <= crc_in;
         left_ff      <= left_in;
         skip_ff      <= skip_in;
         start_seq_ff <= start_seq_in;
      end
   end

endmodule

// ----- design/lrd_queue.sv -----
// Short op queue between the front and back parts of the deframer.
// Depends on lrd_pkg and the shared assertion macros.
`include "log_record_deframer_crc32_macros.svh"

module lrd_queue #(
   parameter int unsigned QueueDepth = lrd_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lrd_pkg::lrd_op_type       push_op,
   input  logic                      pop,
   output lrd_pkg::lrd_op_type       head_op,
   output lrd_pkg::lrd_q_status_type status
);
   import lrd_pkg::*;

   localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

   lrd_op_type          entries_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign status.full     = count_ff == CntW'(QueueDepth);
   assign status.nonempty = count_ff != '0;
   assign head_op         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   `LRD_ASSERT_IMP(a_no_push_full, push, !status.full || pop, "push into full queue")
   `LRD_ASSERT_IMP(a_no_pop_empty, pop, status.nonempty, "pop from empty queue")
   `LRD_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CntW'(QueueDepth), "queue count overrun")

endmodule

// ----- design/lrd_back.sv -----
// Back part: runs the payload CRC, forms verdicts and holds the result register.
// Depends on lrd_pkg, lrd_rsp_if and the shared assertion macros.
`include "log_record_deframer_crc32_macros.svh"

module lrd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lrd_pkg::lrd_q_status_type q_status,
   input  lrd_pkg::lrd_op_type       head_op,
   output logic                      pop,
   lrd_rsp_if.source                 rsp_ch
);
   import lrd_pkg::*;

   logic        halted_ff, halted_in;
   logic [31:0] crc_ff, crc_in;
   logic        valid_ff, valid_in;
   logic        has_byte_ff, has_byte_in;
   logic [7:0]  data_ff, data_in;
   logic [63:0] seq_ff, seq_in;
   logic        last_ff, last_in;
   verdict_type verdict_ff, verdict_in;
   logic [31:0] crc_next;
   logic        good;

   assign pop = q_status.nonempty && (!valid_ff || rsp_ch.ready);

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.has_byte        = has_byte_ff;
   assign rsp_ch.data_byte_res   = data_ff;
   assign rsp_ch.record_sequence = seq_ff;
   assign rsp_ch.last_of_record  = last_ff;
   assign rsp_ch.verdict         = verdict_ff;

   always_comb begin
      crc_next    = lrd_crc_byte(crc_ff, head_op.data);
      good        = 1'b0;
      halted_in   = halted_ff;
      crc_in      = crc_ff;
      valid_in    = valid_ff && !rsp_ch.ready;
      has_byte_in = has_byte_ff;
      data_in     = data_ff;
      seq_in      = seq_ff;
      last_in     = last_ff;
      verdict_in  = verdict_ff;
      if (pop && !halted_ff) begin
         seq_in = head_op.record_seq;
         unique case (head_op.code)
            OP_BYTE: begin
               crc_in = crc_next;
               if (!head_op.skip) begin
                  valid_in    = 1'b1;
                  has_byte_in = 1'b1;
                  data_in     = head_op.data;
                  last_in     = 1'b0;
                  verdict_in  = VERDICT_PENDING;
               end
            end
            OP_LAST, OP_EMPTY: begin
               good = (head_op.code == OP_LAST) ?
                      ((crc_next ^ CRC_ONES) == head_op.check_word) :
                      (head_op.check_word == 32'd0);
               crc_in      = CRC_ONES;
               halted_in   = !good;
               valid_in    = 1'b1;
               has_byte_in = (head_op.code == OP_LAST) && !head_op.skip;
               data_in     = has_byte_in ? head_op.data : 8'd0;
               last_in     = 1'b1;
               verdict_in  = good ? VERDICT_GOOD : VERDICT_MISMATCH;
            end
            OP_TRUNC: begin
               halted_in   = 1'b1;
               valid_in    = 1'b1;
               has_byte_in = 1'b0;
               data_in     = 8'd0;
               last_in     = 1'b1;
               verdict_in  = VERDICT_TRUNCATED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
         crc_ff    <= CRC_ONES;
         valid_ff  <= 1'b0;
      end else begin
         halted_ff <= halted_in;
         crc_ff    <= crc_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      has_byte_ff <= has_byte_in;
      data_ff     <= data_in;
      seq_ff      <= seq_in;
      last_ff     <= last_in;
      verdict_ff  <= verdict_in;
   end

   `LRD_ASSERT_NEXT(a_halt_sticks, halted_ff, halted_ff, "halt released without reset")
   `LRD_ASSERT_IMP(a_pending_mid, valid_ff && !last_ff, verdict_ff == VERDICT_PENDING,
                   "verdict on a non-closing result")
   `LRD_ASSERT_IMP(a_empty_byte, valid_ff && !has_byte_ff, data_ff == 8'd0,
                   "stray data on a result without byte")

endmodule

// ----- design/log_record_deframer_crc32.sv -----
// Top level of the log record deframer with CRC-32 record check.
// Depends on lrd_pkg, lrd_req_if, lrd_rsp_if, lrd_front, lrd_queue and lrd_back.
//
//   channel   direction  handshake          payload
//   req_ch    in         valid/ready        kind, data_byte
//   rsp_ch    out        valid/ready        has_byte, data_byte_res, record_sequence,
//                                           last_of_record, verdict
//   csr       in         csr_we             csr_wdata (start_sequence)
//
// One request a cycle while the queue is not full; results pass the queue, then the
// result register. The rate is set by the combinational CRC byte step in the back part.
// Reset is synchronous and clears all control state at once; no clearing pass.
// A stalled result holds in the output register while the queue of QueueDepth
// ops keeps taking requests; ready falls only when that queue is full.
module log_record_deframer_crc32 #(
   parameter int unsigned QueueDepth = lrd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata,
   lrd_req_if.sink     req_ch,
   lrd_rsp_if.source   rsp_ch
);
   import lrd_pkg::*;

   lrd_q_status_type q_status;
   lrd_op_type       push_op;
   lrd_op_type       head_op;
   logic             push;
   logic             pop;

   lrd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .q_status  (q_status),
      .push      (push),
      .push_op   (push_op)
   );

   lrd_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .status  (q_status)
   );

   lrd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head_op  (head_op),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ----- bench/tb.sv -----
// Testbench for the log record deframer: drives framed log records with random
// payloads and idling, predicts each result and checks it field by field.
// Depends on lrd_pkg, lrd_req_if, lrd_rsp_if and log_record_deframer_crc32.
`timescale 1ns / 100ps

module tb;
   import lrd_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PRESSURE_CYCLES = 150;
   localparam int PHASE_BYTES = 125;

   typedef enum logic [1:0] {AT_HEADER, IN_PAYLOAD, STOPPED} deframe_phase_type;

   typedef enum int {
      HALT_BAD_CRC, HALT_BAD_CRC_SKIPPED, HALT_CUT_HEADER, HALT_CUT_PAYLOAD, HALT_STOP
   } halt_cause_type;

   typedef struct {
      logic        has_byte;
      logic [7:0]  data;
      logic [63:0] seq;
      logic        last;
      verdict_type verdict;
   } record_result_type;

   class deframe_checker_type;
      logic [63:0]       start_seq;
      deframe_phase_type ph;
      logic [3:0]        hdr_pos;
      logic [63:0]       seq_acc;
      logic [31:0]       len;
      logic [31:0]       stored;
      logic [31:0]       crc;
      logic [31:0]       left;
      bit                skip;
      record_result_type due[$];
      int                mismatches;

      function new();
         start_seq = '0;
         ph = AT_HEADER;
         hdr_pos = '0;
         seq_acc = '0;
         len = '0;
         stored = '0;
         crc = '1;
         left = '0;
         skip = 1'b0;
         mismatches = 0;
      endfunction

      static function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
         for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) c = (c >> 1) ^ 32'hEDB8_8320;
            else c = c >> 1;
         end
         return c;
      endfunction

      function void push(logic h, logic [7:0] d, logic l, verdict_type v);
         record_result_type r;
         r.has_byte = h;
         r.data = d;
         r.seq = seq_acc;
         r.last = l;
         r.verdict = v;
         due.push_back(r);
      endfunction

      function verdict_type close_verdict();
         if ((crc ^ 32'hFFFF_FFFF) == stored) begin
            ph = AT_HEADER;
            hdr_pos = '0;
            return VERDICT_GOOD;
         end
         ph = STOPPED;
         return VERDICT_MISMATCH;
      endfunction

      function void note_request(logic [1:0] k, logic [7:0] b);
         int p;
         if (ph == STOPPED) return;
         if (k == KIND_STOP) begin
            ph = STOPPED;
            return;
         end
         if (k == KIND_END) begin
            if (ph == AT_HEADER && hdr_pos == 0) return;
            ph = STOPPED;
            push(1'b0, 8'h00, 1'b1, VERDICT_TRUNCATED);
            return;
         end
         if (k != KIND_BYTE) return;
         if (ph == AT_HEADER) begin
            p = int'(hdr_pos);
            if (p == 0) begin
               seq_acc = '0;
               len = '0;
               stored = '0;
            end
            if (p < 8) seq_acc[8*p +: 8] = b;
            else if (p < 12) len[8*(p-8) +: 8] = b;
            else stored[8*(p-12) +: 8] = b;
            if (hdr_pos != HDR_LAST_POS) begin
               hdr_pos = hdr_pos + 4'd1;
               return;
            end
            hdr_pos = '0;
            crc = '1;
            left = len;
            skip = seq_acc < start_seq;
            if (len == 0) push(1'b0, 8'h00, 1'b1, close_verdict());
            else ph = IN_PAYLOAD;
            return;
         end
         crc = crc32_step(crc, b);
         left = left - 32'd1;
         if (left != 0) begin
            if (!skip) push(1'b1, b, 1'b0, VERDICT_PENDING);
            return;
         end
         if (skip) push(1'b0, 8'h00, 1'b1, close_verdict());
         else push(1'b1, b, 1'b1, close_verdict());
      endfunction

      function void check_result(logic h, logic [7:0] d, logic [63:0] s, logic l,
                                 logic [1:0] v);
         record_result_type e;
         if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: has=%0d byte=%h seq=%h last=%0d verdict=%0d",
                        h, d, s, l, v);
            return;
         end
         e = due.pop_front();
         if (h !== e.has_byte || d !== e.data || s !== e.seq || l !== e.last ||
             v !== e.verdict) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected has=%0d byte=%h seq=%h last=%0d verdict=%0d",
                        e.has_byte, e.data, e.seq, e.last, e.verdict);
               $display("          actual   has=%0d byte=%h seq=%h last=%0d verdict=%0d",
                        h, d, s, l, v);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [63:0] csr_wdata;

   lrd_req_if req_ch();
   lrd_rsp_if rsp_ch();

   deframe_checker_type model = new();
   bit sender_steady = 1'b0;
   bit rsp_held = 1'b0;
   int stream_bytes = 0;

   log_record_deframer_crc32 dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) model.note_request(req_ch.kind, req_ch.data_byte);
         if (rsp_ch.valid && rsp_ch.ready)
            model.check_result(rsp_ch.has_byte, rsp_ch.data_byte_res, rsp_ch.record_sequence,
                               rsp_ch.last_of_record, rsp_ch.verdict);
      end
   end

   task automatic send_req(input logic [1:0] k, input logic [7:0] b);
      int gap;
      gap = (sender_steady || rsp_held) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= k;
      req_ch.data_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 39) == 0) send_req(KIND_UNUSED, 8'($urandom));
      send_req(KIND_BYTE, b);
      stream_bytes++;
   endtask

   task automatic send_header(input logic [63:0] seq, input logic [31:0] len,
                              input logic [31:0] crc, input int count);
      logic [127:0] hdr;
      hdr = {crc, len, seq};
      for (int i = 0; i < count; i++) send_byte(hdr[8*i +: 8]);
   endtask

   task automatic send_record(input logic [63:0] seq, input int unsigned len,
                              input bit corrupt);
      logic [7:0]  body[$];
      logic [31:0] c;
      c = '1;
      for (int i = 0; i < len; i++) begin
         body.push_back(8'($urandom));
         c = deframe_checker_type::crc32_step(c, body[i]);
      end
      c = ~c;
      if (corrupt) c = c ^ (32'h1 << $urandom_range(0, 31));
      send_header(seq, 32'(len), c, 16);
      foreach (body[i]) send_byte(body[i]);
   endtask

   function automatic logic [63:0] pick_seq();
      case ($urandom_range(0, 5))
         0: return model.start_seq;
         1: return model.start_seq - 64'd1;
         2: return model.start_seq + 64'd1;
         3: return '0;
         4: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic int unsigned pick_len();
      if ($urandom_range(0, 7) == 0) return $urandom_range(13, 48);
      return $urandom_range(0, 12);
   endfunction

   task automatic set_start(input logic [63:0] v);
      req_ch.valid <= 1'b0;
      while (model.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      model.start_seq = v;
   endtask

   task automatic run_phase(input logic [63:0] start);
      int first;
      set_start(start);
      sender_steady = $urandom_range(0, 1);
      first = stream_bytes;
      while (stream_bytes - first < PHASE_BYTES) begin
         if ($urandom_range(0, 5) == 0) sender_steady = !sender_steady;
         if ($urandom_range(0, 9) == 0) send_req(KIND_END, 8'($urandom));
         send_record(pick_seq(), pick_len(), 1'b0);
      end
   endtask

   task automatic send_halt();
      halt_cause_type cause;
      cause = halt_cause_type'($urandom_range(0, 4));
      case (cause)
         HALT_BAD_CRC: send_record('1, $urandom_range(0, 6), 1'b1);
         HALT_BAD_CRC_SKIPPED: send_record(model.start_seq - 64'd1, $urandom_range(0, 6), 1'b1);
         HALT_CUT_HEADER: begin
            send_header(pick_seq(), $urandom, $urandom, $urandom_range(1, 15));
            send_req(KIND_END, 8'($urandom));
         end
         HALT_CUT_PAYLOAD: begin
            send_header(pick_seq(), 32'hFFFF_FFFF, $urandom, 16);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
            send_req(KIND_END, 8'($urandom));
         end
         default: begin
            send_header(pick_seq(), $urandom, $urandom, $urandom_range(0, 15));
            send_req(KIND_STOP, 8'($urandom));
         end
      endcase
      repeat (6) send_req(2'($urandom_range(0, 3)), 8'($urandom));
   endtask

   // receiver: random stalls, steady stretches, one long hold-off
   initial begin
      int taken;
      int gap;
      bit steady;
      bit pressure_done;
      taken = 0;
      steady = 1'b0;
      pressure_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) steady = !steady;
         if (taken == 40 && !pressure_done) begin
            pressure_done = 1'b1;
            rsp_held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            rsp_held = 1'b0;
         end else begin
            gap = steady ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall = 0;
         else stall++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.kind <= KIND_BYTE;
      req_ch.data_byte <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_start('0);
      send_req(KIND_END, 8'hFF);
      send_req(KIND_UNUSED, 8'h00);
      send_record('0, 0, 1'b0);
      send_record('1, 1, 1'b0);
      send_record(64'h0123_4567_89AB_CDEF, 3, 1'b0);

      run_phase('0);
      run_phase('1);
      run_phase(64'd1);
      run_phase({$urandom, $urandom} | 64'd1);
      send_halt();

      req_ch.valid <= 1'b0;
      while (model.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (model.mismatches == 0 && model.due.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/lrd_pkg.sv
design/lrd_req_if.sv
design/lrd_rsp_if.sv
design/lrd_front.sv
design/lrd_queue.sv
design/lrd_back.sv
design/log_record_deframer_crc32.sv
bench/tb.sv
